/* hdl/fac_pkg.sv */
// Package for the FIFO-replacement fully associative cache.
// Holds the store depth, item kinds and the controller-to-datapath command type.
// No dependencies.
package fac_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_FILL   = 1'b1
  } kind_t;

  typedef struct packed {
    logic load;
  } fac_cmd_t;

endpackage

/* hdl/fac_ctrl.sv */
// Controller for the FIFO-replacement cache: tracks the output register.
// Issues the load command to fac_dpath. Depends on fac_pkg.
module fac_ctrl
  import fac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output fac_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_FULL  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign out_valid = (state_r == S_FULL);
  assign accept    = in_valid && in_ready;
  assign cmd.load  = accept;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_EMPTY: begin
        if (accept) state_nxt = S_FULL;
      end
      S_FULL: begin
        if (out_ready && !accept) state_nxt = S_EMPTY;
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/fac_dpath.sv */
// Datapath for the FIFO-replacement cache: entry shift store, parallel key
// compare with lowest-position priority, and the result register. Depends on fac_pkg.
module fac_dpath
  import fac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  fac_cmd_t         cmd,
  input  logic             in_kind,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_fill_value,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  output logic             out_evicted
);

  logic [KEY_W-1:0] entry_keys_r   [NUM_ENTRIES];
  logic [VAL_W-1:0] entry_values_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] entry_valid_r;

  logic             match_hit;
  logic [VAL_W-1:0] match_value;
  logic             is_fill;

  logic             hit_r;
  logic [VAL_W-1:0] read_value_r;
  logic             evicted_r;

  assign is_fill = (kind_t'(in_kind) == KIND_FILL);

  always_comb begin
    match_hit   = 1'b0;
    match_value = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid_r[i] && (entry_keys_r[i] == in_key)) begin
        match_hit   = 1'b1;
        match_value = entry_values_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= '0;
    end else if (cmd.load && is_fill) begin
      entry_valid_r <= {entry_valid_r[NUM_ENTRIES-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && is_fill) begin
      for (int i = NUM_ENTRIES - 1; i > 0; i--) begin
        entry_keys_r[i]   <= entry_keys_r[i-1];
        entry_values_r[i] <= entry_values_r[i-1];
      end
      entry_keys_r[0]   <= in_key;
      entry_values_r[0] <= in_fill_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r        <= !is_fill && match_hit;
      read_value_r <= is_fill ? '0 : match_value;
      evicted_r    <= is_fill && entry_valid_r[NUM_ENTRIES-1];
    end
  end

  assign out_hit        = hit_r;
  assign out_read_value = read_value_r;
  assign out_evicted    = evicted_r;

endmodule

/* hdl/fifo_associative_cache_unit.sv */
// Top level of the FIFO-replacement fully associative cache.
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle while out_ready is high; the output register refills on the beat it is taken.
// Reset (rst_n low, synchronous) clears all entry valid bits and empties the
// output register; entry keys and values are not reset. Depends on fac_pkg.
module fifo_associative_cache_unit
  import fac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_fill_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_hit,
  output logic [VAL_W-1:0] out_read_value,
  output logic             out_evicted
);

  fac_cmd_t cmd;

  fac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fac_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_fill_value  (in_fill_value),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  a_fill_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind) |=> (!out_hit && (out_read_value == '0)))
    else $error("fill beat reported a hit or value");

  a_lookup_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_kind) |=> !out_evicted)
    else $error("lookup beat reported an eviction");

  a_miss_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_read_value == '0))
    else $error("miss carries nonzero value");

endmodule

/* test/fac_reply_checker.sv */
// Reply checker for the FIFO-replacement fully associative cache.
// Tracks the entry store on every input beat, predicts each reply and compares it
// with the output beats. Depends on fac_pkg.
module fac_reply_checker
  import fac_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_kind,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_fill_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_hit,
  input  logic [VAL_W-1:0] out_read_value,
  input  logic             out_evicted,
  output int               mismatches,
  output int               outstanding,
  output int               hits,
  output int               evictions
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } cache_reply_t;

  logic [KEY_W-1:0]       line_key [NUM_ENTRIES];
  logic [VAL_W-1:0]       line_val [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] line_valid;
  cache_reply_t           reply_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    hits        = 0;
    evictions   = 0;
    line_valid  = '0;
  end

  function automatic cache_reply_t apply_cache_item(kind_t kind, logic [KEY_W-1:0] key,
                                                     logic [VAL_W-1:0] val);
    cache_reply_t r;
    r = '0;
    if (kind == KIND_LOOKUP) begin
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
        if (line_valid[i] && line_key[i] == key) begin
          r.hit        = 1'b1;
          r.read_value = line_val[i];
        end
      end
    end else begin
      r.evicted = line_valid[NUM_ENTRIES-1];
      for (int i = NUM_ENTRIES - 1; i > 0; i--) begin
        line_key[i]   = line_key[i-1];
        line_val[i]   = line_val[i-1];
        line_valid[i] = line_valid[i-1];
      end
      line_key[0]   = key;
      line_val[0]   = val;
      line_valid[0] = 1'b1;
    end
    return r;
  endfunction

  function automatic void note_mismatch(string field, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: reply %s mismatch: expected %h, got %h", $realtime, field, want, got);
  endfunction

  always @(posedge clk) begin
    cache_reply_t want;
    if (!rst_n) begin
      line_valid = '0;
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply beat with none outstanding: hit %b value %h evicted %b",
                     $realtime, out_hit, out_read_value, out_evicted);
        end else begin
          want = reply_q.pop_front();
          hits      += want.hit;
          evictions += want.evicted;
          if (out_hit !== want.hit) note_mismatch("hit", want.hit, out_hit);
          if (out_read_value !== want.read_value)
            note_mismatch("read_value", want.read_value, out_read_value);
          if (out_evicted !== want.evicted) note_mismatch("evicted", want.evicted, out_evicted);
        end
      end
      if (in_valid && in_ready)
        reply_q.push_back(apply_cache_item(kind_t'(in_kind), in_key, in_fill_value));
    end
    outstanding = reply_q.size();
  end

endmodule

/* test/tb_fifo_associative_cache_unit.sv */
// Testbench top for fifo_associative_cache_unit: drives lookup and fill beats with
// random idling on both channels and gives the verdict from fac_reply_checker.
// Depends on fac_pkg, fac_reply_checker and the block.
module tb_fifo_associative_cache_unit
  import fac_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD = 64;

  logic             clk;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_kind       = 1'b0;
  logic [KEY_W-1:0] in_key        = '0;
  logic [VAL_W-1:0] in_fill_value = '0;
  logic             out_ready     = 1'b0;
  logic             hold_off      = 1'b0;
  logic             long_hold_go  = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic             out_evicted;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int lookups_sent  = 0;
  int fills_sent    = 0;
  int mismatches;
  int outstanding;
  int hits;
  int evictions;

  logic [KEY_W-1:0] key_pool [16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  fifo_associative_cache_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_fill_value  (in_fill_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

  fac_reply_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_fill_value  (in_fill_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .hits           (hits),
    .evictions      (evictions)
  );

  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (long_hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d replies outstanding", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic offer_item(kind_t kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_key        <= key;
    in_fill_value <= val;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_FILL) fills_sent++;
    else lookups_sent++;
  endtask

  task automatic random_items(int count);
    kind_t            kind;
    logic [KEY_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      kind = ($urandom_range(99) < 45) ? KIND_FILL : KIND_LOOKUP;
      key  = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(15)];
      offer_item(kind, key, $urandom());
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = $urandom();
    send_idle_pct = 21;
    recv_idle_pct = 57;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_item(KIND_LOOKUP, '0, $urandom());
    offer_item(KIND_LOOKUP, '1, $urandom());
    offer_item(KIND_FILL, '1, '0);
    offer_item(KIND_FILL, '0, '1);
    offer_item(KIND_LOOKUP, '1, '1);
    offer_item(KIND_LOOKUP, '0, '0);
    offer_item(KIND_FILL, '0, 32'h1234_5678);
    offer_item(KIND_LOOKUP, '0, $urandom());
    for (int i = 0; i < 6; i++)
      offer_item(KIND_FILL, 32'hA5A5_A5A0 ^ i, 32'h5A5A_5A5A ^ (i << 28));
    offer_item(KIND_LOOKUP, '1, $urandom());
    offer_item(KIND_LOOKUP, 32'hA5A5_A5A0, $urandom());
    offer_item(KIND_LOOKUP, '0, $urandom());
    offer_item(KIND_FILL, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    offer_item(KIND_LOOKUP, '0, $urandom());
    offer_item(KIND_FILL, 32'h8000_0001, '1);
    offer_item(KIND_LOOKUP, '0, $urandom());
    offer_item(KIND_LOOKUP, 32'h8000_0001, $urandom());
    offer_item(KIND_LOOKUP, 32'hA5A5_A5A5, $urandom());

    random_items(200);
    send_idle_pct = 57;
    recv_idle_pct = 21;
    random_items(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_go  = 1'b1;
    random_items(200);
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d lookups (%0d hits) and %0d fills (%0d evictions)",
             lookups_sent, hits, fills_sent, evictions);
    $display("under three idle patterns and a %0d-cycle output hold-off", LONG_HOLD);
    if (outstanding != 0) $display("%0d replies never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* fifo_associative_cache_unit.f */
hdl/fac_pkg.sv
hdl/fac_ctrl.sv
hdl/fac_dpath.sv
hdl/fifo_associative_cache_unit.sv
test/fac_reply_checker.sv
test/tb_fifo_associative_cache_unit.sv
